@@ rtl/kphr_pkg.sv @@
// kphr_pkg: shared types and constants of the keypad press/hold/release unit
// no dependencies
`timescale 1ns / 1ps

package kphr_pkg;

  localparam int unsigned NUM_KEYS_DEF = 8;
  localparam int unsigned KEY_W        = 3;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned TICK_W       = 17;
  localparam int unsigned STATE_W      = 3;
  localparam int unsigned PADDR_W      = 4;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [CNT_W-1:0]    ON_THRESHOLD_RST    = 8'd200;
  localparam logic [CNT_W-1:0]    OFF_THRESHOLD_RST   = 8'd50;
  localparam logic [PERIOD_W-1:0] HOLD_PERIOD_RST     = 16'd100;
  localparam logic [PERIOD_W-1:0] RELEASE_TIMEOUT_RST = 16'd10;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE     = 3'd0,
    ST_PUSHED   = 3'd1,
    ST_HOLD     = 3'd2,
    ST_ELAPSED  = 3'd3,
    ST_RELEASE  = 3'd4,
    ST_RELEASED = 3'd5
  } key_state_e;

  typedef enum logic [1:0] {
    REG_ON_THRESHOLD    = 2'd0,
    REG_OFF_THRESHOLD   = 2'd1,
    REG_HOLD_PERIOD     = 2'd2,
    REG_RELEASE_TIMEOUT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]    on_threshold;
    logic [CNT_W-1:0]    off_threshold;
    logic [PERIOD_W-1:0] hold_period;
    logic [PERIOD_W-1:0] release_timeout;
  } cfg_t;

  typedef struct packed {
    key_state_e        key_state;
    logic [TICK_W-1:0] hold_ticks;
    logic [TICK_W-1:0] release_ticks;
  } key_entry_t;

endpackage

@@ rtl/kphr_cfg_regs.sv @@
// kphr_cfg_regs: APB register block for thresholds, hold period and release timeout
// depends on kphr_pkg
`timescale 1ns / 1ps

module kphr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kphr_pkg::PADDR_W-1:0]   paddr,
  input  logic [kphr_pkg::PDATA_W-1:0]   pwdata,
  output logic [kphr_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output kphr_pkg::cfg_t                 cfg_o
);

  kphr_pkg::cfg_t   cfg_q;
  kphr_pkg::cfg_reg_e reg_sel;
  logic             wr_en;

  assign reg_sel = kphr_pkg::cfg_reg_e'(paddr[kphr_pkg::PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_threshold    <= kphr_pkg::ON_THRESHOLD_RST;
      cfg_q.off_threshold   <= kphr_pkg::OFF_THRESHOLD_RST;
      cfg_q.hold_period     <= kphr_pkg::HOLD_PERIOD_RST;
      cfg_q.release_timeout <= kphr_pkg::RELEASE_TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        kphr_pkg::REG_ON_THRESHOLD:
          cfg_q.on_threshold <= pwdata[kphr_pkg::CNT_W-1:0];
        kphr_pkg::REG_OFF_THRESHOLD:
          cfg_q.off_threshold <= pwdata[kphr_pkg::CNT_W-1:0];
        kphr_pkg::REG_HOLD_PERIOD:
          cfg_q.hold_period <= pwdata[kphr_pkg::PERIOD_W-1:0];
        kphr_pkg::REG_RELEASE_TIMEOUT:
          cfg_q.release_timeout <= pwdata[kphr_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kphr_pkg::REG_ON_THRESHOLD:
        prdata = {{(kphr_pkg::PDATA_W-kphr_pkg::CNT_W){1'b0}}, cfg_q.on_threshold};
      kphr_pkg::REG_OFF_THRESHOLD:
        prdata = {{(kphr_pkg::PDATA_W-kphr_pkg::CNT_W){1'b0}}, cfg_q.off_threshold};
      kphr_pkg::REG_HOLD_PERIOD:
        prdata = {{(kphr_pkg::PDATA_W-kphr_pkg::PERIOD_W){1'b0}}, cfg_q.hold_period};
      kphr_pkg::REG_RELEASE_TIMEOUT:
        prdata = {{(kphr_pkg::PDATA_W-kphr_pkg::PERIOD_W){1'b0}}, cfg_q.release_timeout};
      default:
        prdata = '0;
    endcase
  end

endmodule

@@ rtl/kphr_key_step.sv @@
// kphr_key_step: one transition of a key's six-state machine with its tick counters
// depends on kphr_pkg
`timescale 1ns / 1ps

module kphr_key_step (
  input  kphr_pkg::cfg_t                cfg_i,
  input  logic [kphr_pkg::CNT_W-1:0]    bounce_count_i,
  input  kphr_pkg::key_entry_t          cur_i,
  output kphr_pkg::key_entry_t          next_o,
  output kphr_pkg::key_state_e          reported_state_o
);

  logic                          pressed;
  logic                          let_go;
  logic [kphr_pkg::TICK_W-1:0]   hold_bump;
  logic [kphr_pkg::TICK_W-1:0]   rel_bump;
  logic                          hold_over;
  logic                          rel_over;
  kphr_pkg::key_state_e          state_d;

  assign pressed = bounce_count_i > cfg_i.on_threshold;
  assign let_go  = bounce_count_i < cfg_i.off_threshold;

  // saturating tick counters
  assign hold_bump = (&cur_i.hold_ticks) ? cur_i.hold_ticks
                                         : cur_i.hold_ticks + 1'b1;
  assign rel_bump  = (&cur_i.release_ticks) ? cur_i.release_ticks
                                            : cur_i.release_ticks + 1'b1;
  assign hold_over = hold_bump > {1'b0, cfg_i.hold_period};
  assign rel_over  = rel_bump > {1'b0, cfg_i.release_timeout};

  // next state
  always_comb begin
    state_d = cur_i.key_state;
    case (cur_i.key_state)
      kphr_pkg::ST_IDLE: begin
        if (pressed) state_d = kphr_pkg::ST_PUSHED;
      end
      kphr_pkg::ST_PUSHED:   state_d = kphr_pkg::ST_HOLD;
      kphr_pkg::ST_HOLD: begin
        if (pressed && hold_over) state_d = kphr_pkg::ST_ELAPSED;
        if (let_go) state_d = kphr_pkg::ST_RELEASE;
      end
      kphr_pkg::ST_ELAPSED:  state_d = kphr_pkg::ST_HOLD;
      kphr_pkg::ST_RELEASE: begin
        if (rel_over) state_d = kphr_pkg::ST_RELEASED;
      end
      kphr_pkg::ST_RELEASED: state_d = kphr_pkg::ST_IDLE;
      default:               state_d = kphr_pkg::ST_IDLE;
    endcase
  end

  // counters and report
  always_comb begin
    next_o           = cur_i;
    next_o.key_state = state_d;
    reported_state_o = cur_i.key_state;
    case (cur_i.key_state)
      kphr_pkg::ST_PUSHED:   next_o.hold_ticks = '0;
      kphr_pkg::ST_HOLD: begin
        if (pressed) next_o.hold_ticks = hold_bump;
        if (let_go) next_o.release_ticks = '0;
      end
      kphr_pkg::ST_ELAPSED:  next_o.hold_ticks = '0;
      kphr_pkg::ST_RELEASE:  next_o.release_ticks = rel_bump;
      kphr_pkg::ST_RELEASED: next_o.release_ticks = '0;
      kphr_pkg::ST_IDLE: ;
      default:               reported_state_o = kphr_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/key_press_hold_release_fsm_unit.sv @@
// key_press_hold_release_fsm_unit: an accepted beat goes through the input register and
// the result register; one beat per cycle sustained while out_stall_i is low, set by the
// combinational per-key state update between the two registers; back-to-back beats for
// the same key see each other's update. reset loads the register defaults and puts every
// key in not pushed with cleared counters at once, with no clearing pass
// depends on kphr_pkg, kphr_cfg_regs, kphr_key_step
`timescale 1ns / 1ps

module key_press_hold_release_fsm_unit #(
  parameter int unsigned NUM_KEYS = kphr_pkg::NUM_KEYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kphr_pkg::PADDR_W-1:0]  paddr,
  input  logic [kphr_pkg::PDATA_W-1:0]  pwdata,
  output logic [kphr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kphr_pkg::KEY_W-1:0]    key_index_i,
  input  logic [kphr_pkg::CNT_W-1:0]    bounce_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kphr_pkg::STATE_W-1:0]  reported_state_o
);

  // only keys reachable through the index field need storage
  localparam int unsigned KeyReach = 1 << kphr_pkg::KEY_W;
  localparam int unsigned KeyDepth = (NUM_KEYS < KeyReach) ? NUM_KEYS : KeyReach;
  localparam int unsigned IdxW     = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam logic [kphr_pkg::KEY_W:0] KeyLimit = (kphr_pkg::KEY_W + 1)'(KeyDepth);

  kphr_pkg::cfg_t                cfg;
  kphr_pkg::key_entry_t          keys_q [KeyDepth];
  kphr_pkg::key_entry_t          cur_entry;
  kphr_pkg::key_entry_t          next_entry;
  kphr_pkg::key_state_e          step_state;

  logic                          s1_valid_q;
  logic [kphr_pkg::KEY_W-1:0]    s1_key_q;
  logic [kphr_pkg::CNT_W-1:0]    s1_cnt_q;
  logic                          out_valid_q;
  logic [kphr_pkg::STATE_W-1:0]  out_state_q;
  logic [kphr_pkg::STATE_W-1:0]  out_state_d;

  logic                          advance;
  logic                          in_range;
  logic [IdxW-1:0]               rd_idx;

  kphr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  assign in_range  = {1'b0, s1_key_q} < KeyLimit;
  assign rd_idx    = in_range ? IdxW'(s1_key_q) : '0;
  assign cur_entry = keys_q[rd_idx];

  kphr_key_step u_step (
    .cfg_i            (cfg),
    .bounce_count_i   (s1_cnt_q),
    .cur_i            (cur_entry),
    .next_o           (next_entry),
    .reported_state_o (step_state)
  );

  assign out_state_d = in_range ? step_state : kphr_pkg::ST_IDLE;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_key_q <= key_index_i;
      s1_cnt_q <= bounce_count_i;
    end
  end

  // per-key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KeyDepth; k++) begin
        keys_q[k] <= '0;
      end
    end else if (s1_valid_q && advance && in_range) begin
      keys_q[rd_idx] <= next_entry;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_state_q <= out_state_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reported_state_o = out_state_q;

endmodule
